// ----- design/dkma_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dkma_pkg: shared codes for the k-permit mutual exclusion agent
// Input kinds, result kinds, configuration register indexes, queue depth and states.
// ---------------------------------------------------------------------------
package dkma_pkg;

  localparam logic [2:0] KIND_LOCK   = 3'd0;
  localparam logic [2:0] KIND_UNLOCK = 3'd1;
  localparam logic [2:0] KIND_RLOCK  = 3'd2;
  localparam logic [2:0] KIND_RALLOW = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  localparam logic [1:0] RES_LOCK    = 2'd0;
  localparam logic [1:0] RES_ALLOW   = 2'd1;
  localparam logic [1:0] RES_GRANT   = 2'd2;
  localparam logic [1:0] RES_REJECT  = 2'd3;

  localparam logic [2:0] REG_RANK    = 3'd0;
  localparam logic [2:0] REG_PCOUNT  = 3'd1;
  localparam logic [2:0] REG_CAP0    = 3'd2;
  localparam logic [2:0] REG_CAP3    = 3'd5;

  localparam int DEFER_DEPTH = 15;

  // Lamport clock width
  localparam int CLOCK_BITS = 32;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_BCAST = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

endpackage

// ----- design/distributed_k_mutex_agent_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// distributed_k_mutex_agent_top: one node's Ricart-Agrawala k-permit agent
// Lamport clock, per-semaphore stamps, deferred request queues in a RAM.
// ---------------------------------------------------------------------------
// A result made in the decide state is registered in the cycle after acceptance.
// A lock walks ranks 0..pc-1 (process_count capped at MAX_PROCS) at one per
// cycle while the output is free; an unlock drains deferred entries through
// the read and drain states, sending each one when the output is free.
// Reset: synchronous, clears control state, clock to 1, all semaphores unlocked.
module distributed_k_mutex_agent_top
  import dkma_pkg::*;
#(
  parameter int NUM_SEMS   = 4,
  parameter int MAX_PROCS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  // sem[1:0], sender[5:2], packet_clock[37:6], msg_lock_clock[69:38]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_kind[1:0]
  output logic [1:0]  m_tuser,
  // dest[3:0], out_clock[35:4], out_sem[37:36], out_lock_clock[69:38]
  output logic [71:0] m_tdata,
  output logic        m_tlast
);

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;
  localparam int AW = SW + 4;

  // configuration
  logic [3:0] own_rank;
  logic [4:0] process_count;
  logic [4:0] capacity [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_rank <= '0;
      process_count <= 5'd1;
      for (int i = 0; i < 4; i++) capacity[i] <= 5'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_RANK) own_rank <= cfg_data[3:0];
      else if (cfg_index == REG_PCOUNT) process_count <= cfg_data;
      else if (cfg_index >= REG_CAP0 && cfg_index <= REG_CAP3)
        capacity[2'(cfg_index - REG_CAP0)] <= cfg_data;
    end
  end

  // captured request
  logic [2:0]  kind;
  logic [1:0]  sem;
  logic [3:0]  sender;
  logic [31:0] pkt;
  logic [31:0] req;

  // state
  state_t state;
  logic [CLOCK_BITS-1:0] lclock;
  logic [CLOCK_BITS-1:0] stamp [NUM_SEMS];
  logic [NUM_SEMS-1:0] confirmed;
  logic [3:0] dcount [NUM_SEMS];
  logic waiting;
  logic [SW-1:0] wsem;
  logic [4:0] approvals;
  logic [4:0] idx;

  // deferred queue RAM: {rank, stamp}
  logic [35:0] dmem [NUM_SEMS*16];
  logic [35:0] drd;
  logic dwe;
  logic [AW-1:0] dwa, dra;
  logic [35:0] dwd;

  always_ff @(posedge clk) begin
    if (dwe) dmem[dwa] <= dwd;
    drd <= dmem[dra];
  end

  // output register
  logic [71:0] odata;
  logic olast, ovalid;
  assign m_tvalid = ovalid;
  assign m_tuser  = odata[1:0];
  assign m_tdata  = {2'b0, odata[71:2]};
  assign m_tlast  = olast;
  wire out_free = !ovalid || m_tready;

  assign s_tready = (state == ST_IDLE) && !ovalid;

  wire [CLOCK_BITS-1:0] tick1 = (lclock == CLK_MAX) ? lclock : lclock + 1'b1;
  wire [4:0] pc = (process_count > 5'(MAX_PROCS)) ? 5'(MAX_PROCS) : process_count;
  wire sem_ok = 32'(sem) < 32'(NUM_SEMS);
  wire [SW-1:0] si = sem[SW-1:0];
  wire signed [6:0] needed = $signed({2'b0, pc}) - $signed({2'b0, capacity[sem]});

  logic [CLOCK_BITS-1:0] rcv_clk;
  always_comb begin
    logic [CLOCK_BITS-1:0] p;
    p = CLOCK_BITS'(pkt);
    if (p < lclock) p = lclock;
    rcv_clk = (p == CLK_MAX) ? p : p + 1'b1;
  end

  // clock after receive plus one send
  wire [CLOCK_BITS-1:0] rcv_tick = (rcv_clk == CLK_MAX) ? rcv_clk : rcv_clk + 1'b1;

  // allow a received lock when unlocked, or unconfirmed and the request is older
  wire rlock_allow = (stamp[si] == '0) || (!confirmed[si] &&
                     (stamp[si] > CLOCK_BITS'(req) ||
                      (stamp[si] == CLOCK_BITS'(req) && own_rank >= sender)));
  wire defer_ok = dcount[si] < 4'(DEFER_DEPTH);
  wire defer_req = (kind == KIND_RLOCK) && sem_ok && !rlock_allow && defer_ok;

  function automatic logic [71:0] pack(logic [1:0] k, logic [3:0] d,
      logic [CLOCK_BITS-1:0] c, logic [1:0] s, logic [31:0] l);
    pack = {l, s, c[31:0], d, k};
  endfunction

  // last broadcast destination below pc other than own rank
  wire [4:0] last_dest = (own_rank == 4'(pc - 1'b1)) ? pc - 5'd2 : pc - 5'd1;

  always_comb begin
    dra = {si, idx[3:0]};
  end

  always_ff @(posedge clk) begin
    logic ovalid_next;
    ovalid_next = ovalid && !m_tready;
    dwe <= !rst && (state == ST_DECIDE) && defer_req;
    if (rst) begin
      state <= ST_IDLE;
      lclock <= CLOCK_BITS'(1);
      confirmed <= '0;
      waiting <= 1'b0;
      wsem <= '0;
      approvals <= '0;
      ovalid <= 1'b0;
      idx <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        stamp[i] <= '0;
        dcount[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= s_tuser;
            sem <= s_tdata[1:0];
            sender <= s_tdata[5:2];
            pkt <= s_tdata[37:6];
            req <= s_tdata[69:38];
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          idx <= '0;
          if (kind == KIND_LOCK || kind == KIND_UNLOCK) begin
            if (waiting || !sem_ok) begin
              odata <= pack(RES_REJECT, own_rank, lclock, sem, '0);
              olast <= 1'b1;
              ovalid_next = 1'b1;
              state <= ST_IDLE;
            end else if (kind == KIND_LOCK) begin
              lclock <= tick1;
              stamp[si] <= tick1;
              state <= ST_BCAST;
            end else begin
              lclock <= tick1;
              stamp[si] <= '0;
              confirmed[si] <= 1'b0;
              state <= (dcount[si] != 0) ? ST_READ : ST_IDLE;
            end
          end else if (kind inside {KIND_RLOCK, KIND_RALLOW, KIND_OTHER}) begin
            state <= ST_IDLE;
            if (kind == KIND_RLOCK && sem_ok) begin
              if (rlock_allow) begin
                odata <= pack(RES_ALLOW, sender, rcv_tick, sem, req);
                lclock <= rcv_tick;
                olast <= 1'b1;
                ovalid_next = 1'b1;
              end else begin
                lclock <= rcv_clk;
                if (defer_ok) begin
                  dwa <= {si, dcount[si]};
                  dwd <= {sender, req};
                  dcount[si] <= dcount[si] + 1'b1;
                end
              end
            end else begin
              lclock <= rcv_clk;
              if (kind == KIND_RALLOW && waiting && sem_ok && si == wsem &&
                  stamp[si] == CLOCK_BITS'(req)) begin
                if (approvals != 5'd31) approvals <= approvals + 1'b1;
                if ($signed({2'b0, (approvals == 5'd31) ? approvals : approvals + 5'd1})
                    >= needed) begin
                  waiting <= 1'b0;
                  confirmed[si] <= 1'b1;
                  odata <= pack(RES_GRANT, own_rank, rcv_clk, sem, 32'(stamp[si]));
                  olast <= 1'b1;
                  ovalid_next = 1'b1;
                end
              end
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_BCAST: begin
          if (out_free) begin
            if (idx >= pc) begin
              state <= ST_IDLE;
              if (needed <= 0) begin
                confirmed[si] <= 1'b1;
                odata <= pack(RES_GRANT, own_rank, lclock, sem, 32'(stamp[si]));
                olast <= 1'b1;
                ovalid_next = 1'b1;
              end else begin
                waiting <= 1'b1; wsem <= si; approvals <= '0;
              end
            end else if (idx[3:0] == own_rank) begin
              idx <= idx + 1'b1;
            end else begin
              lclock <= tick1;
              odata <= pack(RES_LOCK, idx[3:0], tick1, sem, 32'(stamp[si]));
              olast <= (needed > 0) && (idx == last_dest);
              ovalid_next = 1'b1;
              idx <= idx + 1'b1;
            end
          end
        end
        ST_READ: state <= ST_DRAIN;
        ST_DRAIN: begin
          if (out_free) begin
            lclock <= tick1;
            odata <= pack(RES_ALLOW, drd[35:32], tick1, sem, drd[31:0]);
            ovalid_next = 1'b1;
            if (idx[3:0] + 1'b1 == dcount[si]) begin
              olast <= 1'b1;
              dcount[si] <= '0;
              state <= ST_IDLE;
            end else begin
              olast <= 1'b0;
              idx <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      ovalid <= ovalid_next;
    end
  end

`ifndef SYNTH
  a_wait_sem: assert property (@(posedge clk) disable iff (rst)
    waiting |-> stamp[wsem] != 0) else $error("waiting on unlocked semaphore");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !ovalid) else $error("accept with pending result");
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    lclock >= $past(lclock) || $past(rst)) else $error("clock went backward");
`endif

endmodule

// ----- bench/tb_distributed_k_mutex_agent_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_distributed_k_mutex_agent_top: bench for the k-permit mutual exclusion agent
// Sends local calls and received packets into the agent. A behavioral copy of
// the agent computes the expected messages, grants and rejects, and each
// result that leaves the block is compared field by field with them.
// ---------------------------------------------------------------------------
module tb_distributed_k_mutex_agent_top;
  import dkma_pkg::*;

  localparam int SEMS = 4;
  localparam int PROCS = 16;
  localparam int LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [3:0]  dest;
    logic [31:0] clk_out;
    logic [1:0]  sem;
    logic [31:0] lock_clk;
    logic        last;
  } agent_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [2:0]  s_tuser = '0;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;
  logic [71:0] m_tdata;
  logic        m_tlast;

  distributed_k_mutex_agent_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .s_tdata(s_tdata), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  // Agent copy: configuration and protocol state
  logic [3:0]  my_rank;
  logic [4:0]  node_count;
  logic [4:0]  permits [SEMS];
  logic [31:0] lamport;
  logic [31:0] stamp [SEMS];
  logic        confirmed [SEMS];
  logic [3:0]  defer_rank [SEMS][DEFER_DEPTH];
  logic [31:0] defer_clk [SEMS][DEFER_DEPTH];
  int          defer_cnt [SEMS];
  logic        waiting;
  logic [1:0]  wait_sem;
  int          approvals;

  agent_result_t expected_results[$];
  int    errors = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_off = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_left = 0;

  function automatic void tick_clock();
    if (lamport != 32'hFFFF_FFFF) lamport++;
  endfunction

  function automatic void merge_clock(logic [31:0] pkt);
    if (pkt > lamport) lamport = pkt;
    tick_clock();
  endfunction

  function automatic int approvals_needed(logic [1:0] s);
    int pc;
    pc = node_count > PROCS ? PROCS : node_count;
    return pc - int'(permits[s]);
  endfunction

  function automatic void push_result(logic [1:0] k, logic [3:0] d, logic [1:0] s,
                                      logic [31:0] lc);
    agent_result_t r;
    r.rkind = k; r.dest = d; r.clk_out = lamport; r.sem = s; r.lock_clk = lc;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Work out the results of one request and queue them
  function automatic void predict_agent(logic [2:0] kind, logic [1:0] s, logic [3:0] snd,
                                        logic [31:0] pkt, logic [31:0] req);
    int before_n;
    int pc;
    bit allow;
    before_n = expected_results.size();
    if (kind == KIND_LOCK || kind == KIND_UNLOCK) begin
      if (waiting) begin
        push_result(RES_REJECT, my_rank, s, 32'd0);
      end else if (kind == KIND_LOCK) begin
        pc = node_count > PROCS ? PROCS : node_count;
        tick_clock();
        stamp[s] = lamport;
        for (int i = 0; i < pc; i++) begin
          if (i != my_rank) begin
            tick_clock();
            push_result(RES_LOCK, 4'(i), s, stamp[s]);
          end
        end
        if (approvals_needed(s) <= 0) begin
          confirmed[s] = 1'b1;
          push_result(RES_GRANT, my_rank, s, stamp[s]);
        end else begin
          waiting = 1'b1; wait_sem = s; approvals = 0;
        end
      end else begin
        tick_clock();
        stamp[s] = '0;
        confirmed[s] = 1'b0;
        for (int i = 0; i < defer_cnt[s]; i++) begin
          tick_clock();
          push_result(RES_ALLOW, defer_rank[s][i], s, defer_clk[s][i]);
        end
        defer_cnt[s] = 0;
      end
    end else if (kind == KIND_RLOCK) begin
      merge_clock(pkt);
      if (stamp[s] == 0) allow = 1'b1;
      else if (confirmed[s]) allow = 1'b0;
      else if (stamp[s] < req) allow = 1'b0;
      else if (stamp[s] == req && my_rank < snd) allow = 1'b0;
      else allow = 1'b1;
      if (allow) begin
        tick_clock();
        push_result(RES_ALLOW, snd, s, req);
      end else if (defer_cnt[s] < DEFER_DEPTH) begin
        defer_rank[s][defer_cnt[s]] = snd;
        defer_clk[s][defer_cnt[s]] = req;
        defer_cnt[s]++;
      end
    end else if (kind == KIND_RALLOW) begin
      merge_clock(pkt);
      if (waiting && s == wait_sem && stamp[s] == req) begin
        if (approvals < 31) approvals++;
        if (approvals >= approvals_needed(s)) begin
          waiting = 1'b0;
          confirmed[s] = 1'b1;
          push_result(RES_GRANT, my_rank, s, stamp[s]);
        end
      end
    end else if (kind == KIND_OTHER) begin
      merge_clock(pkt);
    end
    if (expected_results.size() > before_n)
      expected_results[$].last = 1'b1;
  endfunction

  // Send one request and predict it when accepted; drop valid while idling
  task automatic send_request(logic [2:0] kind, logic [1:0] s, logic [3:0] snd,
                              logic [31:0] pkt, logic [31:0] req);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'd0, req, pkt, snd, s};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_agent(kind, s, snd, pkt, req);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RANK:   my_rank = val[3:0];
      REG_PCOUNT: node_count = val;
      default:    permits[idx - REG_CAP0] = val;
    endcase
  endtask

  task automatic set_config(logic [3:0] rank, logic [4:0] pc, logic [4:0] cap);
    write_reg(REG_RANK, {1'b0, rank});
    write_reg(REG_PCOUNT, pc);
    for (int i = 0; i < SEMS; i++) write_reg(3'(REG_CAP0 + i), cap);
    cfg_we <= 1'b0;
  endtask

  // Random 32-bit stamp, often near the extremes
  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(5, 0))
      0: return 32'hFFFF_FFFF - $urandom_range(3, 0);
      1: return $urandom_range(3, 0);
      2: return $urandom();
      default: return lamport + $urandom_range(20, 0);
    endcase
  endfunction

  // Extremes, each kind and the special cases
  task automatic test_directed();
    set_config(4'd2, 5'd4, 5'd2);
    send_request(KIND_OTHER, 2'd0, 4'd0, 32'd0, 32'd0);
    send_request(KIND_RLOCK, 2'd1, 4'd3, 32'd5, 32'd3);
    send_request(KIND_LOCK, 2'd1, 4'd0, 32'd0, 32'd0);
    send_request(KIND_LOCK, 2'd2, 4'd0, 32'd0, 32'd0);
    send_request(KIND_UNLOCK, 2'd2, 4'd0, 32'd0, 32'd0);
    send_request(KIND_RLOCK, 2'd1, 4'd15, 32'd0, 32'hFFFF_FFFF);
    send_request(KIND_RLOCK, 2'd1, 4'd0, 32'd0, stamp[1]);
    send_request(KIND_RLOCK, 2'd1, 4'd3, 32'd0, stamp[1]);
    send_request(KIND_RALLOW, 2'd0, 4'd1, 32'd0, stamp[1]);
    send_request(KIND_RALLOW, 2'd1, 4'd1, 32'd0, 32'd7);
    send_request(KIND_RALLOW, 2'd1, 4'd1, 32'd0, stamp[1]);
    send_request(KIND_RALLOW, 2'd1, 4'd3, 32'd0, stamp[1]);
    send_request(KIND_RLOCK, 2'd1, 4'd1, 32'd0, 32'd0);
    send_request(3'd5, 2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 2'd0, 4'd0, 32'd0, 32'd0);
    send_request(KIND_UNLOCK, 2'd1, 4'd0, 32'd0, 32'd0);
    send_request(KIND_OTHER, 2'd3, 4'd15, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(KIND_RLOCK, 2'd3, 4'd9, 32'hFFFF_FFFF, 32'd1);
    send_request(KIND_LOCK, 2'd3, 4'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Fill a deferred queue past its depth, then drain it
  task automatic test_defer_overflow();
    set_config(4'd15, 5'd16, 5'd16);
    send_request(KIND_LOCK, 2'd0, 4'd0, 32'd0, 32'd0);
    for (int i = 0; i < DEFER_DEPTH + 2; i++)
      send_request(KIND_RLOCK, 2'd0, 4'($urandom_range(15, 0)),
                   $urandom_range(100, 0), $urandom());
    send_request(KIND_UNLOCK, 2'd0, 4'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Well-formed lock rounds with random contention, plus noise
  task automatic test_random(int n_items);
    logic [1:0] s;
    for (int i = 0; i < n_items; i++) begin
      s = 2'($urandom_range(3, 0));
      case ($urandom_range(9, 0))
        0, 1: send_request(KIND_LOCK, s, 4'($urandom_range(15, 0)), $urandom(), $urandom());
        2:    send_request(KIND_UNLOCK, s, 4'($urandom_range(15, 0)), $urandom(), $urandom());
        3, 4: send_request(KIND_RALLOW, waiting ? wait_sem : s, 4'($urandom_range(15, 0)),
                           rand_stamp(), waiting ? stamp[wait_sem] : $urandom());
        5, 6: send_request(KIND_RLOCK, s, 4'($urandom_range(15, 0)), rand_stamp(),
                           $urandom_range(1, 0) ? stamp[s] : rand_stamp());
        7:    send_request(KIND_OTHER, s, 4'($urandom_range(15, 0)), rand_stamp(), $urandom());
        8:    send_request(3'($urandom_range(7, 5)), s, 4'($urandom_range(15, 0)),
                           $urandom(), $urandom());
        default: send_request(KIND_RALLOW, s, 4'($urandom_range(15, 0)), rand_stamp(),
                              rand_stamp());
      endcase
    end
    wait_drained();
  endtask

  // Stall the output for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_config(4'd0, 5'd16, 5'd0);
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_request(KIND_LOCK, 2'(i), 4'd0, 32'd0, 32'd0);
    hold_off = 1'b0;
    wait_drained();
  endtask

  // Receiver: random stall, plus one long counted hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (!hold_off) hold_done <= 1'b0;
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    agent_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.rkind = m_tuser;
      got.dest = m_tdata[3:0];
      got.clk_out = m_tdata[35:4];
      got.sem = m_tdata[37:36];
      got.lock_clk = m_tdata[69:38];
      got.last = m_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected kind %0d dest %0d clk %h sem %0d lc %h last %0d, got kind %0d dest %0d clk %h sem %0d lc %h last %0d",
                     want.rkind, want.dest, want.clk_out, want.sem, want.lock_clk, want.last,
                     got.rkind, got.dest, got.clk_out, got.sem, got.lock_clk, got.last);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("distributed_k_mutex_agent_top: mismatch");
      $finish;
    end
  end

  initial begin
    my_rank = '0; node_count = 5'd1; lamport = 32'd1;
    waiting = 1'b0; wait_sem = '0; approvals = 0;
    for (int i = 0; i < SEMS; i++) begin
      permits[i] = 5'd1; stamp[i] = '0; confirmed[i] = 1'b0; defer_cnt[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 23; recv_idle_pct = 64;
    test_directed();
    test_defer_overflow();
    set_config(4'd5, 5'd1, 5'd1);
    test_random(12);
    send_idle_pct = 64; recv_idle_pct = 23;
    set_config(4'd3, 5'd6, 5'd3);
    test_random(30);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config(4'd1, 5'd3, 5'd16);
    test_random(12);
    set_config(4'd7, 5'd31, 5'd14);
    test_random(8);
    test_backpressure();
    if (errors == 0) begin
      $display("distributed_k_mutex_agent_top: match");
    end else begin
      $display("distributed_k_mutex_agent_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dkma_pkg.sv
design/distributed_k_mutex_agent_top.sv
bench/tb_distributed_k_mutex_agent_top.sv
